[sv/hfbs_pkg.sv]
// Shared types, constants and the CRC step function for the HDLC bit serializer.
// Used by hfbs_front, hfbs_back and the top level; depends on nothing else.
`default_nettype none

package hfbs_pkg;

	// Input kind codes as they arrive on the slave-side tuser.
	localparam logic [1:0] KIND_START  = 2'd0;
	localparam logic [1:0] KIND_BYTE   = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// Frame constants.
	localparam logic [15:0] CRC_PRESET  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'h8408;
	localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
	localparam logic [7:0]  BYTE_MASK   = 8'hFF;
	localparam logic [2:0]  STUFF_LIMIT = 3'd5;
	localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

	// Command queue geometry.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// Operations handed from the front part to the back part.
	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_BYTE  = 2'd1,
		OP_END   = 2'd2
	} op_t;

	// One classified command.
	typedef struct packed {
		op_t        op;
		logic [7:0] value;
		logic       as_flag;
	} cmd_t;

	// Handshake between the queue and the back part.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_req_t;

	// One step of the reflected CRC-16 over a single data bit.
	function automatic logic [15:0] crc_bit(input logic [15:0] crc, input logic b);
		logic [15:0] r;
		r = {1'b0, crc[15:1]};
		if (crc[0] ^ b) begin
			r = r ^ CRC_POLY;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[sv/hdlc_frame_bit_serializer.sv]
// HDLC frame bit serializer: one NRZI line bit per cycle on the master side while
// m_axis_tready lets the output register drain. The command queue accepts new
// requests while earlier ones are still being serialized, as long as it has room.
// Reset: CRC all ones, tone at mark, ones run zero, command queue and output empty.
// Depends on hfbs_pkg, hfbs_front and hfbs_back.
`default_nettype none

module hdlc_frame_bit_serializer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [7:0] byte_value
	input  wire logic [1:0] s_axis_tuser,  // [1:0] kind
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // [0] tone_level, [7:1] zero
	output logic [0:0]      m_axis_tuser,  // [0] stuffed_bit
	output logic            m_axis_tlast   // last_bit
);
	import hfbs_pkg::*;

	cmd_req_t cmd_req;
	logic     cmd_take;
	logic     tone;
	logic     stuffed;

	// Accept and classify requests into the command queue.
	hfbs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_kind  (s_axis_tuser),
		.in_byte  (s_axis_tdata),
		.cmd_req  (cmd_req),
		.cmd_take (cmd_take)
	);

	// Serialize commands into line bits.
	hfbs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_req     (cmd_req),
		.cmd_take    (cmd_take),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_tone    (tone),
		.out_stuffed (stuffed),
		.out_last    (m_axis_tlast)
	);

	assign m_axis_tdata = {7'd0, tone};
	assign m_axis_tuser = stuffed;

endmodule

`default_nettype wire

[sv/hfbs_front.sv]
// Front part: accepts input requests, classifies them and queues commands.
// Depends on hfbs_pkg.
`default_nettype none

module hfbs_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        in_kind,
	input  wire logic [7:0]        in_byte,
	output hfbs_pkg::cmd_req_t     cmd_req,
	input  wire logic              cmd_take
);
	import hfbs_pkg::*;

	cmd_t                  mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_CW-1:0]   count_q;
	logic                  push;
	logic                  pop;
	cmd_t                  new_cmd;

	// Classify the request; the unused kind is dropped without a queue slot.
	always_comb begin
		new_cmd.value   = in_byte;
		new_cmd.as_flag = (in_byte == FLAG_BYTE);
		unique case (in_kind)
			KIND_START: new_cmd.op = OP_START;
			KIND_BYTE:  new_cmd.op = OP_BYTE;
			default:    new_cmd.op = OP_END;
		endcase
	end

	assign in_ready = (count_q != QUEUE_CW'(QUEUE_DEPTH));
	assign push     = in_valid && in_ready && (in_kind != KIND_UNUSED);
	assign pop      = cmd_take && (count_q != '0);

	assign cmd_req.valid = (count_q != '0);
	assign cmd_req.cmd   = mem_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_cmd;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[sv/hfbs_back.sv]
// Back part: serializes queued commands into NRZI line bits with stuffing and CRC.
// Holds the frame state and the output register. Depends on hfbs_pkg.
`default_nettype none

module hfbs_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire hfbs_pkg::cmd_req_t cmd_req,
	output logic                    cmd_take,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    out_tone,
	output logic                    out_stuffed,
	output logic                    out_last
);
	import hfbs_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DATA = 5'b00010,
		ST_LO   = 5'b00100,
		ST_HI   = 5'b01000,
		ST_FLAG = 5'b10000
	} state_t;

	state_t      state_q, state_n;
	logic [7:0]  shift_q, shift_n;
	logic [7:0]  hi_q, hi_n;
	logic [3:0]  cnt_q, cnt_n;
	logic        flag_q, flag_n;
	logic        stuff_q, stuff_n;
	logic [15:0] crc_q, crc_n;
	logic [2:0]  ones_q, ones_n;
	logic        tone_q, tone_n;

	logic        can_emit;
	logic        emit;
	logic        emit_tone;
	logic        emit_stuffed;
	logic        byte_done;
	logic        emit_last;
	logic [2:0]  ones_eff;

	logic        out_valid_q;
	logic        out_tone_q;
	logic        out_stuffed_q;
	logic        out_last_q;

	assign can_emit = !out_valid_q || out_ready;

	// Bit engine: one bit per cycle unless stalled; byte sequencing, command load.
	always_comb begin
		state_n      = state_q;
		shift_n      = shift_q;
		hi_n         = hi_q;
		cnt_n        = cnt_q;
		flag_n       = flag_q;
		stuff_n      = stuff_q;
		crc_n        = crc_q;
		ones_n       = ones_q;
		tone_n       = tone_q;
		emit         = 1'b0;
		emit_tone    = tone_q;
		emit_stuffed = 1'b0;
		byte_done    = 1'b0;
		ones_eff     = flag_q ? 3'd0 : ones_q;

		if ((state_q != ST_IDLE) && can_emit) begin
			emit = 1'b1;
			if (stuff_q) begin
				// Inserted stuffing period: toggled tone, run cleared.
				tone_n       = ~tone_q;
				ones_n       = '0;
				stuff_n      = 1'b0;
				emit_stuffed = 1'b1;
				byte_done    = (cnt_q == BITS_PER_BYTE);
			end else begin
				// Data bit, least significant first.
				shift_n = {1'b0, shift_q[7:1]};
				cnt_n   = cnt_q + 4'd1;
				if (!flag_q) begin
					crc_n = crc_bit(crc_q, shift_q[0]);
				end
				if (!shift_q[0]) begin
					tone_n = ~tone_q;
					ones_n = '0;
				end else begin
					ones_n = ones_eff + 3'd1;
				end
				stuff_n   = shift_q[0] && (ones_n == STUFF_LIMIT);
				byte_done = (cnt_q == BITS_PER_BYTE - 4'd1) && !stuff_n;
			end
			emit_tone = tone_n;
		end

		emit_last = byte_done && ((state_q == ST_DATA) || (state_q == ST_FLAG));

		// Move to the next byte of a closing sequence, or go idle after a last byte.
		if (byte_done) begin
			cnt_n = '0;
			priority case (1'b1)
				state_q == ST_LO: begin
					shift_n = hi_q;
					flag_n  = 1'b0;
					state_n = ST_HI;
				end
				state_q == ST_HI: begin
					shift_n = FLAG_BYTE;
					flag_n  = 1'b1;
					state_n = ST_FLAG;
				end
				default: begin
					state_n = ST_IDLE;
				end
			endcase
		end

		// Take the next command when idle or when this bit finishes the item.
		cmd_take = cmd_req.valid && ((state_q == ST_IDLE) || emit_last);
		if (cmd_take) begin
			cnt_n   = '0;
			stuff_n = 1'b0;
			unique case (cmd_req.cmd.op)
				OP_START: begin
					crc_n   = CRC_PRESET;
					state_n = ST_IDLE;
				end
				OP_BYTE: begin
					shift_n = cmd_req.cmd.value;
					flag_n  = cmd_req.cmd.as_flag;
					state_n = ST_DATA;
				end
				default: begin
					shift_n = crc_n[7:0] ^ BYTE_MASK;
					hi_n    = crc_n[15:8] ^ BYTE_MASK;
					flag_n  = 1'b0;
					state_n = ST_LO;
				end
			endcase
		end
	end

	// Frame state and sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			flag_q  <= 1'b0;
			stuff_q <= 1'b0;
			crc_q   <= CRC_PRESET;
			ones_q  <= '0;
			tone_q  <= 1'b1;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
			flag_q  <= flag_n;
			stuff_q <= stuff_n;
			crc_q   <= crc_n;
			ones_q  <= ones_n;
			tone_q  <= tone_n;
		end
	end

	// Byte shifters.
	always_ff @(posedge clk) begin
		shift_q <= shift_n;
		hi_q    <= hi_n;
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_emit) begin
			out_valid_q <= emit;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (can_emit) begin
			out_tone_q    <= emit_tone;
			out_stuffed_q <= emit_stuffed;
			out_last_q    <= emit_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_tone    = out_tone_q;
	assign out_stuffed = out_stuffed_q;
	assign out_last    = out_last_q;

endmodule

`default_nettype wire
